// ----- sv/env_sensor_compensation_core_assert.svh -----
// Assertion macros used by the checker file.
`ifndef ENV_SENSOR_COMPENSATION_CORE_ASSERT_SVH
`define ENV_SENSOR_COMPENSATION_CORE_ASSERT_SVH

// same-cycle implication
`define ESC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("esc assertion failed");

// next-cycle implication
`define ESC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("esc assertion failed");

`endif

// ----- sv/esc_pkg.sv -----
`default_nettype none
package esc_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [2:0] CFG_TEMP       = 3'd0;
	localparam logic [2:0] CFG_PRESS_LOW  = 3'd1;
	localparam logic [2:0] CFG_PRESS_HIGH = 3'd2;
	localparam logic [2:0] CFG_PRESS_LAST = 3'd3;
	localparam logic [2:0] CFG_HUM        = 3'd4;
	localparam logic [2:0] CFG_KIND       = 3'd5;

	localparam logic [19:0] RAW_T_UNMEASURED = 20'h80000;
	localparam logic [15:0] RAW_H_SKIPPED    = 16'h8000;
	localparam logic [16:0] HUM_NOMINAL      = 17'd51200;
	localparam logic [16:0] HUM_MAX_Q10      = 17'd102400;
	localparam logic [24:0] PRESS_MAX_Q8     = 25'd32000000;
	localparam logic [14:0] TEMP_MIN_C       = 15'h7060; // -4000
	localparam logic [14:0] TEMP_MAX_C       = 15'd8500;
	localparam logic signed [63:0] TEMP_MIN_W = -64'sd4000;
	localparam logic signed [63:0] TEMP_MAX_W = 64'sd8500;
	localparam logic signed [63:0] PRESS_MAX_W = 64'sd32000000;
	localparam logic signed [63:0] HUM_CLAMP_W = 64'sd419430400;
	localparam logic [63:0] TF_HUM_ORIGIN   = 64'd76800;
	localparam logic [63:0] TF_PRESS_ORIGIN = 64'd128000;

	typedef struct packed {
		logic [47:0] temp;
		logic [63:0] press_low;
		logic [63:0] press_high;
		logic [15:0] press_last;
		logic [63:0] hum;
		logic        kind;
	} cfg_t;

	typedef struct packed {
		logic [19:0] raw_pressure;
		logic [19:0] raw_temperature;
		logic [15:0] raw_humidity;
		logic        invalid;
		logic        nominal;
	} item_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_MUL,
		B_DIV,
		B_DONE
	} bst_t;

	typedef enum logic [4:0] {
		S_TA, S_TB, S_TF, S_TC,
		S_SQ, S_V2A, S_V2B, S_UA, S_UB, S_DEN, S_NUM,
		S_WA, S_WB, S_V2C, S_PR,
		S_HA, S_HB, S_HC, S_HD, S_HE, S_HX, S_HY, S_HZ, S_HW
	} step_t;

	function automatic logic [63:0] sx16(input logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

	function automatic logic [63:0] sx12(input logic [11:0] v);
		return {{52{v[11]}}, v};
	endfunction

	function automatic logic [63:0] sx8(input logic [7:0] v);
		return {{56{v[7]}}, v};
	endfunction

	function automatic logic [63:0] asr64(input logic [63:0] v, input int unsigned n);
		logic signed [63:0] s;
		s = v;
		return s >>> n;
	endfunction

endpackage
`default_nettype wire

// ----- sv/esc_front.sv -----
`default_nettype none
module esc_front (
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic [55:0]   s_tdata,
	input  wire logic          kind,
	input  wire logic          q_full,
	output logic               q_wr,
	output esc_pkg::item_t     q_item
);

	logic [19:0] rt;
	logic [15:0] rh;

	assign rt = s_tdata[39:20];
	assign rh = s_tdata[55:40];
	assign s_tready = !q_full;
	assign q_wr = s_tvalid && !q_full;

	always_comb begin
		q_item.raw_pressure    = s_tdata[19:0];
		q_item.raw_temperature = rt;
		q_item.raw_humidity    = rh;
		q_item.invalid = (rt == esc_pkg::RAW_T_UNMEASURED) || (rt == 20'd0);
		q_item.nominal = kind || (rh == esc_pkg::RAW_H_SKIPPED);
	end

endmodule
`default_nettype wire

// ----- sv/esc_queue.sv -----
`default_nettype none
module esc_queue #(
	parameter int unsigned Depth = esc_pkg::QUEUE_DEPTH
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  wire esc_pkg::item_t wr_data,
	output logic               full,
	input  wire logic          rd_en,
	output logic               rd_valid,
	output esc_pkg::item_t     rd_data
);

	localparam int unsigned PtrW = $clog2(Depth);
	localparam int unsigned CntW = $clog2(Depth + 1);

	esc_pkg::item_t mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] cnt_q;
	logic do_wr, do_rd;

	assign full = (cnt_q == CntW'(Depth));
	assign rd_valid = (cnt_q != '0);
	assign rd_data = mem_q[rd_ptr_q];
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(wr_ptr_q + 1'b1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(rd_ptr_q + 1'b1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= CntW'(cnt_q + 1'b1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= CntW'(cnt_q - 1'b1);
			end
		end
	end

endmodule
`default_nettype wire

// ----- sv/esc_back.sv -----
`default_nettype none
module esc_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire esc_pkg::cfg_t  cfg,
	input  wire logic           q_valid,
	input  wire esc_pkg::item_t q_item,
	output logic                q_rd,
	output logic                m_tvalid,
	input  wire logic           m_tready,
	output logic [63:0]         m_tdata,
	output logic [0:0]          m_tuser
);

	esc_pkg::bst_t  state_q, state_d;
	esc_pkg::step_t step_q;
	logic [2:0] ph_q;
	logic [5:0] cnt_q;
	logic load_out, step_end;

	esc_pkg::item_t item_q;
	logic [63:0] opa_q, opb_q, acc_q;
	logic [63:0] opa_d, opb_d;
	logic [31:0] mul_x, mul_y;
	logic [63:0] mul_p;

	logic [63:0] ta_q, tb_q, tf_q, tc_q, sq_q, v2_q, u_q, den_q, p_q, w_q, pr_q;
	logic [63:0] ha_q, hb_q, hc_q, hx_q, hy_q, hz_q;
	logic [63:0] rem_q, dvd_q;
	logic        neg_q;
	logic [63:0] trial, qnext;
	logic        ge;

	logic        out_valid_q, out_status_q;
	logic [14:0] out_temp_q;
	logic [24:0] out_press_q;
	logic [16:0] out_hum_q;
	logic [14:0] temp_d;
	logic [24:0] press_d;
	logic [16:0] hum_d;

	logic [15:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, h2;
	logic [7:0]  h1, h3, h6;
	logic [11:0] h4, h5;
	logic [63:0] v1, hx, hpre;

	assign t1 = cfg.temp[15:0];
	assign t2 = cfg.temp[31:16];
	assign t3 = cfg.temp[47:32];
	assign p1 = cfg.press_low[15:0];
	assign p2 = cfg.press_low[31:16];
	assign p3 = cfg.press_low[47:32];
	assign p4 = cfg.press_low[63:48];
	assign p5 = cfg.press_high[15:0];
	assign p6 = cfg.press_high[31:16];
	assign p7 = cfg.press_high[47:32];
	assign p8 = cfg.press_high[63:48];
	assign p9 = cfg.press_last;
	assign h1 = cfg.hum[7:0];
	assign h2 = cfg.hum[23:8];
	assign h3 = cfg.hum[31:24];
	assign h4 = cfg.hum[43:32];
	assign h5 = cfg.hum[55:44];
	assign h6 = cfg.hum[63:56];

	assign v1 = tf_q - esc_pkg::TF_PRESS_ORIGIN;
	assign hx = tf_q - esc_pkg::TF_HUM_ORIGIN;
	assign hpre = (64'(item_q.raw_humidity) << 14) - (esc_pkg::sx12(h4) << 20) + 64'd16384;

	// operand select
	always_comb begin
		opa_d = '0;
		opb_d = '0;
		case (step_q)
			esc_pkg::S_TA: begin
				opa_d = 64'(item_q.raw_temperature[19:3]) - 64'({t1, 1'b0});
				opb_d = esc_pkg::sx16(t2);
			end
			esc_pkg::S_TB: begin
				opa_d = 64'(item_q.raw_temperature[19:4]) - 64'(t1);
				opb_d = 64'(item_q.raw_temperature[19:4]) - 64'(t1);
			end
			esc_pkg::S_TF: begin opa_d = tb_q; opb_d = esc_pkg::sx16(t3); end
			esc_pkg::S_TC: begin opa_d = tf_q; opb_d = 64'd5; end
			esc_pkg::S_SQ: begin opa_d = v1; opb_d = v1; end
			esc_pkg::S_V2A: begin opa_d = sq_q; opb_d = esc_pkg::sx16(p6); end
			esc_pkg::S_V2B: begin opa_d = v1; opb_d = esc_pkg::sx16(p5) << 17; end
			esc_pkg::S_UA: begin opa_d = sq_q; opb_d = esc_pkg::sx16(p3); end
			esc_pkg::S_UB: begin opa_d = v1; opb_d = esc_pkg::sx16(p2) << 12; end
			esc_pkg::S_DEN: begin opa_d = u_q + (64'd1 << 47); opb_d = 64'(p1); end
			esc_pkg::S_NUM: begin
				opa_d = ((64'd1048576 - 64'(item_q.raw_pressure)) << 31) - v2_q;
				opb_d = 64'd3125;
			end
			esc_pkg::S_WA: begin opa_d = esc_pkg::sx16(p9); opb_d = esc_pkg::asr64(p_q, 13); end
			esc_pkg::S_WB: begin opa_d = w_q; opb_d = esc_pkg::asr64(p_q, 13); end
			esc_pkg::S_V2C: begin opa_d = esc_pkg::sx16(p8); opb_d = p_q; end
			esc_pkg::S_PR: begin opa_d = p_q + w_q; opb_d = 64'd1; end
			esc_pkg::S_HA: begin opa_d = esc_pkg::sx12(h5); opb_d = 64'd0 - hx; end
			esc_pkg::S_HB: begin opa_d = hx; opb_d = esc_pkg::sx8(h6); end
			esc_pkg::S_HC: begin opa_d = hx; opb_d = 64'(h3); end
			esc_pkg::S_HD: begin opa_d = hb_q; opb_d = hc_q; end
			esc_pkg::S_HE: begin opa_d = hb_q; opb_d = esc_pkg::sx16(h2); end
			esc_pkg::S_HX: begin opa_d = ha_q; opb_d = hb_q; end
			esc_pkg::S_HY: begin
				opa_d = esc_pkg::asr64(hx_q, 15);
				opb_d = esc_pkg::asr64(hx_q, 15);
			end
			esc_pkg::S_HZ: begin opa_d = hy_q; opb_d = 64'(h1); end
			esc_pkg::S_HW: begin opa_d = hx_q - hz_q; opb_d = 64'd1; end
			default: begin opa_d = '0; opb_d = '0; end
		endcase
	end

	// one 32x32 multiplier, three partial products per 64-bit step
	always_comb begin
		case (ph_q)
			3'd2: begin mul_x = opa_q[31:0];  mul_y = opb_q[63:32]; end
			3'd3: begin mul_x = opa_q[63:32]; mul_y = opb_q[31:0]; end
			default: begin mul_x = opa_q[31:0]; mul_y = opb_q[31:0]; end
		endcase
	end
	assign mul_p = 64'(mul_x) * 64'(mul_y);

	assign step_end = (state_q == esc_pkg::B_MUL) && (ph_q == 3'd4);

	// divider datapath
	assign trial = {rem_q[62:0], dvd_q[63]};
	assign ge = (trial >= den_q);
	assign qnext = {dvd_q[62:0], ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= esc_pkg::B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		q_rd = 1'b0;
		load_out = 1'b0;
		case (state_q)
			esc_pkg::B_IDLE: begin
				if (q_valid) begin
					q_rd = 1'b1;
					state_d = esc_pkg::B_MUL;
				end
			end
			esc_pkg::B_MUL: begin
				if (step_end && step_q == esc_pkg::S_NUM) begin
					state_d = esc_pkg::B_DIV;
				end else if (step_end && step_q == esc_pkg::S_HW) begin
					state_d = esc_pkg::B_DONE;
				end
			end
			esc_pkg::B_DIV: begin
				if (cnt_q == 6'd63) begin
					state_d = esc_pkg::B_MUL;
				end
			end
			esc_pkg::B_DONE: begin
				if (!out_valid_q || m_tready) begin
					load_out = 1'b1;
					state_d = esc_pkg::B_IDLE;
				end
			end
			default: state_d = esc_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= esc_pkg::S_TA;
			ph_q <= '0;
			cnt_q <= '0;
		end else begin
			if (q_rd) begin
				step_q <= esc_pkg::S_TA;
				ph_q <= '0;
			end else if (step_end) begin
				ph_q <= '0;
				if (step_q != esc_pkg::S_HW) begin
					step_q <= esc_pkg::step_t'(5'(step_q + 5'd1));
				end
			end else if (state_q == esc_pkg::B_MUL) begin
				ph_q <= 3'(ph_q + 3'd1);
			end
			if (state_q == esc_pkg::B_DIV) begin
				cnt_q <= 6'(cnt_q + 6'd1);
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			item_q <= q_item;
		end
		if (state_q == esc_pkg::B_MUL) begin
			case (ph_q)
				3'd0: begin opa_q <= opa_d; opb_q <= opb_d; end
				3'd1: acc_q <= mul_p;
				3'd2: acc_q <= acc_q + {mul_p[31:0], 32'd0};
				3'd3: acc_q <= acc_q + {mul_p[31:0], 32'd0};
				default: acc_q <= acc_q;
			endcase
		end
		if (step_end) begin
			case (step_q)
				esc_pkg::S_TA: ta_q <= esc_pkg::asr64(acc_q, 11);
				esc_pkg::S_TB: tb_q <= esc_pkg::asr64(acc_q, 12);
				esc_pkg::S_TF: tf_q <= ta_q + esc_pkg::asr64(acc_q, 14);
				esc_pkg::S_TC: tc_q <= esc_pkg::asr64(acc_q + 64'd128, 8);
				esc_pkg::S_SQ: sq_q <= acc_q;
				esc_pkg::S_V2A: v2_q <= acc_q + (esc_pkg::sx16(p4) << 35);
				esc_pkg::S_V2B: v2_q <= v2_q + acc_q;
				esc_pkg::S_UA: u_q <= esc_pkg::asr64(acc_q, 8);
				esc_pkg::S_UB: u_q <= u_q + acc_q;
				esc_pkg::S_DEN: den_q <= esc_pkg::asr64(acc_q, 33);
				esc_pkg::S_NUM: begin
					dvd_q <= acc_q[63] ? 64'd0 - acc_q : acc_q;
					neg_q <= acc_q[63];
					rem_q <= '0;
				end
				esc_pkg::S_WA: w_q <= acc_q;
				esc_pkg::S_WB: w_q <= esc_pkg::asr64(acc_q, 25);
				esc_pkg::S_V2C: v2_q <= esc_pkg::asr64(acc_q, 19);
				esc_pkg::S_PR: pr_q <= esc_pkg::asr64(acc_q + v2_q, 8) + (esc_pkg::sx16(p7) << 4);
				esc_pkg::S_HA: ha_q <= esc_pkg::asr64(acc_q + hpre, 15);
				esc_pkg::S_HB: hb_q <= esc_pkg::asr64(acc_q, 10);
				esc_pkg::S_HC: hc_q <= esc_pkg::asr64(acc_q, 11) + 64'd32768;
				esc_pkg::S_HD: hb_q <= esc_pkg::asr64(acc_q, 10) + 64'd2097152;
				esc_pkg::S_HE: hb_q <= esc_pkg::asr64(acc_q + 64'd8192, 14);
				esc_pkg::S_HX: hx_q <= acc_q;
				esc_pkg::S_HY: hy_q <= esc_pkg::asr64(acc_q, 7);
				esc_pkg::S_HZ: hz_q <= esc_pkg::asr64(acc_q, 4);
				esc_pkg::S_HW: hx_q <= acc_q;
				default: ta_q <= ta_q;
			endcase
		end
		if (state_q == esc_pkg::B_DIV) begin
			rem_q <= ge ? trial - den_q : trial;
			dvd_q <= qnext;
			if (cnt_q == 6'd63) begin
				p_q <= neg_q ? 64'd0 - qnext : qnext;
			end
		end
	end

	// final saturation and special cases
	always_comb begin
		if ($signed(tc_q) < esc_pkg::TEMP_MIN_W) begin
			temp_d = esc_pkg::TEMP_MIN_C;
		end else if ($signed(tc_q) > esc_pkg::TEMP_MAX_W) begin
			temp_d = esc_pkg::TEMP_MAX_C;
		end else begin
			temp_d = tc_q[14:0];
		end
		if ($signed(den_q) < 64'sd1 || $signed(pr_q) < 64'sd0) begin
			press_d = '0;
		end else if ($signed(pr_q) > esc_pkg::PRESS_MAX_W) begin
			press_d = esc_pkg::PRESS_MAX_Q8;
		end else begin
			press_d = pr_q[24:0];
		end
		if (item_q.nominal) begin
			hum_d = esc_pkg::HUM_NOMINAL;
		end else if (hx == 64'd0 || $signed(hx_q) < 64'sd0) begin
			hum_d = '0;
		end else if ($signed(hx_q) > esc_pkg::HUM_CLAMP_W) begin
			hum_d = esc_pkg::HUM_MAX_Q10;
		end else begin
			hum_d = hx_q[28:12];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_status_q <= item_q.invalid;
			out_temp_q <= item_q.invalid ? '0 : temp_d;
			out_press_q <= item_q.invalid ? '0 : press_d;
			out_hum_q <= item_q.invalid ? '0 : hum_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser = out_status_q;
	assign m_tdata = {7'd0, out_hum_q, out_press_q, out_temp_q};

endmodule
`default_nettype wire

// ----- sv/env_sensor_compensation_core.sv -----
// channel  direction  handshake              payload
// s_*      in         s_tvalid / s_tready    tdata: raw_pressure, raw_temperature, raw_humidity
// m_*      out        m_tvalid / m_tready    tdata: temperature, pressure, humidity; tuser: status
// cfg_*    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each request runs 24 steps on the shared 32x32 multiplier
// plus the radix-2 pressure divider, and a hand-off.
// Up to QueueDepth requests wait in the queue while one is computed and one result is held.
// arst_n clears all control state and the coefficient registers to zero.
// A stalled m_tready holds the result; the next request is computed meanwhile.
`default_nettype none
module env_sensor_compensation_core #(
	parameter int unsigned QueueDepth = esc_pkg::QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [55:0] s_tdata,  // raw_pressure[19:0], raw_temperature[39:20], raw_humidity[55:40]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,  // temperature_centi[14:0], pressure_q8[39:15], humidity_q10[56:40]
	output logic [0:0]       m_tuser,  // status[0]
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);

	esc_pkg::cfg_t  cfg_q;
	esc_pkg::item_t wr_item, rd_item;
	logic q_full, q_wr, q_rd, q_valid;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				esc_pkg::CFG_TEMP:       cfg_q.temp <= cfg_data[47:0];
				esc_pkg::CFG_PRESS_LOW:  cfg_q.press_low <= cfg_data;
				esc_pkg::CFG_PRESS_HIGH: cfg_q.press_high <= cfg_data;
				esc_pkg::CFG_PRESS_LAST: cfg_q.press_last <= cfg_data[15:0];
				esc_pkg::CFG_HUM:        cfg_q.hum <= cfg_data;
				esc_pkg::CFG_KIND:       cfg_q.kind <= cfg_data[0];
				default:                 cfg_q <= cfg_q;
			endcase
		end
	end

	esc_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.kind     (cfg_q.kind),
		.q_full   (q_full),
		.q_wr     (q_wr),
		.q_item   (wr_item)
	);

	esc_queue #(.Depth(QueueDepth)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (q_wr),
		.wr_data  (wr_item),
		.full     (q_full),
		.rd_en    (q_rd),
		.rd_valid (q_valid),
		.rd_data  (rd_item)
	);

	esc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (q_valid),
		.q_item   (rd_item),
		.q_rd     (q_rd),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
`default_nettype wire

// ----- sv/esc_checker.sv -----
`default_nettype none
`include "env_sensor_compensation_core_assert.svh"
module esc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [55:0] s_tdata,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [63:0] m_tdata,
	input wire logic [0:0]  m_tuser,
	input wire logic        cfg_valid,
	input wire logic        cfg_ready,
	input wire logic [2:0]  cfg_index,
	input wire logic [63:0] cfg_data
);

	`ESC_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	`ESC_ASSERT_NOW(a_invalid_zero, clk, arst_n, m_tvalid && m_tuser[0], m_tdata == 64'd0)
	`ESC_ASSERT_NOW(a_range, clk, arst_n, m_tvalid,
		m_tdata[39:15] <= 25'd32000000 && m_tdata[56:40] <= 17'd102400 && m_tdata[63:57] == 7'd0)
	`ESC_ASSERT_NOW(a_out_known, clk, arst_n, m_tvalid,
		!$isunknown(m_tdata) && !$isunknown(m_tuser))

endmodule

bind env_sensor_compensation_core esc_checker u_esc_checker (.*);
`default_nettype wire
